// ----- design/adf_pkg.sv -----
// ---------------------------------------------------------------------------
// adf_pkg: shared types and constants
// Operation codes, register offsets, field masks and reset values for the
// converter interface register block.
// ---------------------------------------------------------------------------
package adf_pkg;

   typedef enum logic [2:0] {
      OP_BUS_READ  = 3'd0,
      OP_BUS_WRITE = 3'd1,
      OP_ADC_PUSH  = 3'd2,
      OP_DMA_POP   = 3'd3,
      OP_DMA_DAC   = 3'd4,
      OP_DRAIN     = 3'd5
   } op_type;

   // register offsets
   localparam logic [11:0] REG_ADC_CFG    = 12'h000;
   localparam logic [11:0] REG_ADC_DATA   = 12'h004;
   localparam logic [11:0] REG_TRAIN      = 12'h020;
   localparam logic [11:0] REG_DAC_CFG    = 12'h040;
   localparam logic [11:0] REG_DAC_DMA    = 12'h044;
   localparam logic [11:0] REG_DAC_DATA   = 12'h048;
   localparam logic [11:0] REG_DAC_STATUS = 12'h04c;

   localparam logic [31:0] ADC_CTRL_MASK = 32'h00c0_7001;
   localparam logic [31:0] TRAIN_MASK    = 32'h0003_001f;
   localparam logic [31:0] TRAIN_RESET   = 32'h0000_000f;
   localparam logic [31:0] DACCFG_MASK   = 32'h00ff_0701;
   localparam logic [31:0] DACCFG_FIXED  = 32'h0d00_0000;
   localparam logic [7:0]  DACDMA_MASK   = 8'hf3;

   localparam int SAMPLE_W  = 26;
   localparam int DAC_TW    = 2;
   localparam int DAC_CW    = 3;
   localparam int ADC_CNT_W = 6;

   localparam logic [3:0] BUS_SIZE = 4'd4;

   typedef struct packed {
      logic push;     // store one sample at the tail
      logic pop;      // advance the head (sample known present)
      logic clear;    // reset pointers and count
      logic capture;  // register the sample at the head
   } adc_cmd_type;

   typedef struct packed {
      logic push;      // one DAC entry written
      logic check;     // control rewritten, re-evaluate drain
      logic drain;     // drain tick
      logic can;       // drain allowed by the new control values
   } dac_cmd_type;

endpackage

// ----- design/adc_dac_fifo_register_block.sv -----
// ---------------------------------------------------------------------------
// adc_dac_fifo_register_block: converter interface register block
// Register window with an ADC sample FIFO and a DAC write queue, driven by a
// stream of bus accesses, sample pushes, DMA beats and drain ticks.
// req_ carries one operation per word: tuser holds the operation code,
// tdata the offset, access size and data. rsp_ returns exactly one word
// per request: read data and the DMA ready and drain pending flags as
// they stand after that request.
// The path is an input register, one pass of decode and state update, and
// an output register. One request is taken every cycle while results drain.
// The head sample of the ADC store is read through a clocked port in the
// same pass, so a pop does not hold up the stream.
// When rsp_tready is low the output word holds, the input register fills,
// and req_tready drops until the result is taken.
// Reset (synchronous) empties both pipeline stages and both queues and
// loads the control registers with their power-on values; sample store
// contents are not cleared.
// ---------------------------------------------------------------------------
module adc_dac_fifo_register_block #(
   parameter int ADC_DEPTH    = 32,
   parameter int DAC_DEPTH    = 4,
   parameter int WINDOW_BYTES = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [2:0]  req_tuser,    // operation
   input  logic [47:0] req_tdata,    // offset[11:0], access_size[15:12], data[47:16]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata     // read_data[31:0], adc_dma_ready[32],
                                     // dac_dma_ready[33], drain_pending[34], zero pad
);
   import adf_pkg::*;

   localparam int ADC_CW = $clog2(ADC_DEPTH + 1);

   // input stage
   logic        in_valid_ff, in_valid_in;
   op_type      op_ff;
   logic [11:0] offset_ff;
   logic [3:0]  size_ff;
   logic [31:0] data_ff;

   // control state
   logic [31:0] adc_ctrl_ff, adc_ctrl_in;
   logic [31:0] train_ff, train_in;
   logic [31:0] dac_ctrl_ff, dac_ctrl_in;
   logic [7:0]  dac_dma_ff, dac_dma_in;
   logic        overrun_ff, overrun_in;
   logic        underrun_ff, underrun_in;

   // output stage
   logic        out_valid_ff, out_valid_in;
   logic [31:0] rd_ff, rd_in;
   logic [31:0] pop_mask_ff, pop_mask_in;
   logic        adc_rdy_ff, dac_rdy_ff, drain_ff;

   logic        advance;
   logic        bus_ok;
   logic        pop_req, pop_go;
   logic [3:0]  pop_size;
   logic        adc_full;

   adc_cmd_type             adc_cmd;
   dac_cmd_type             dac_cmd;
   logic [ADC_CW-1:0]       smp_fill, smp_fill_next;
   logic [SAMPLE_W-1:0]     sample;
   logic [DAC_TW-1:0]       dq_ptr;
   logic [DAC_CW-1:0]       dq_fill, dq_fill_next;
   logic                    drain_next;

   assign advance      = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready   = !in_valid_ff || advance;
   assign in_valid_in  = (req_tvalid && req_tready) ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign out_valid_in = advance ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         op_ff     <= op_type'(req_tuser);
         offset_ff <= req_tdata[11:0];
         size_ff   <= req_tdata[15:12];
         data_ff   <= req_tdata[47:16];
      end
   end

   // decode
   assign bus_ok = (size_ff == BUS_SIZE) && (offset_ff[1:0] == 2'b00)
                && ({1'b0, offset_ff} < 13'(WINDOW_BYTES));
   assign adc_full = (smp_fill == ADC_CW'(ADC_DEPTH));

   always_comb begin
      pop_req  = 1'b0;
      pop_size = BUS_SIZE;
      case (op_ff)
         OP_BUS_READ: pop_req = bus_ok && (offset_ff == REG_ADC_DATA);
         OP_DMA_POP: begin
            pop_req  = 1'b1;
            pop_size = size_ff;
         end
         default: pop_req = 1'b0;
      endcase
   end

   assign pop_go = pop_req && (pop_size <= BUS_SIZE) && adc_ctrl_ff[0] && (smp_fill != '0);

   always_comb begin
      adc_ctrl_in = adc_ctrl_ff;
      train_in    = train_ff;
      dac_ctrl_in = dac_ctrl_ff;
      dac_dma_in  = dac_dma_ff;
      overrun_in  = overrun_ff;
      underrun_in = underrun_ff;
      adc_cmd     = '0;
      dac_cmd     = '0;
      rd_in       = '0;

      if (pop_req && !pop_go) begin
         underrun_in = 1'b1;
      end
      adc_cmd.pop = pop_go;

      case (op_ff)
         OP_BUS_READ: begin
            if (bus_ok) begin
               case (offset_ff)
                  REG_ADC_CFG: begin
                     rd_in = (adc_ctrl_ff & ADC_CTRL_MASK)
                           | ((smp_fill != '0) ? 32'h14 : 32'h0)
                           | (adc_full ? 32'h8 : 32'h0)
                           | {25'd0, underrun_ff, overrun_ff, 5'd0}
                           | (32'(smp_fill) << 16);
                  end
                  REG_TRAIN:   rd_in = train_ff;
                  REG_DAC_CFG: rd_in = dac_ctrl_ff;
                  REG_DAC_DMA: rd_in = {24'd0, dac_dma_ff};
                  REG_DAC_STATUS: begin
                     // read pointer never moves: shows 8 when empty, else 0
                     rd_in = ((dq_fill == '0) ? 32'h81 : 32'h0)
                           | ((dq_fill == DAC_CW'(DAC_DEPTH)) ? 32'h2 : 32'h0)
                           | {22'd0, dq_ptr, 8'd0};
                  end
                  default: rd_in = '0;
               endcase
            end
         end
         OP_BUS_WRITE: begin
            if (bus_ok) begin
               case (offset_ff)
                  REG_ADC_CFG: begin
                     adc_ctrl_in   = data_ff & ADC_CTRL_MASK;
                     adc_cmd.clear = data_ff[1];
                     if (data_ff[9]) begin
                        overrun_in = 1'b0;
                     end
                     if (data_ff[10]) begin
                        underrun_in = 1'b0;
                     end
                  end
                  REG_TRAIN:    train_in = (train_ff & ~TRAIN_MASK) | (data_ff & TRAIN_MASK);
                  REG_DAC_CFG: begin
                     dac_ctrl_in   = DACCFG_FIXED | (data_ff & DACCFG_MASK);
                     dac_cmd.check = 1'b1;
                  end
                  REG_DAC_DMA: begin
                     dac_dma_in    = data_ff[7:0] & DACDMA_MASK;
                     dac_cmd.check = 1'b1;
                  end
                  REG_DAC_DATA: dac_cmd.push = 1'b1;
                  default: dac_cmd.push = 1'b0;
               endcase
            end
         end
         OP_ADC_PUSH: begin
            if (adc_full) begin
               overrun_in = 1'b1;
            end else begin
               adc_cmd.push = 1'b1;
            end
         end
         OP_DMA_DAC: dac_cmd.push  = 1'b1;
         OP_DRAIN:   dac_cmd.drain = 1'b1;
         default:    rd_in = '0;
      endcase

      dac_cmd.can = dac_ctrl_in[0] || dac_dma_in[0];

      // nothing moves unless the word is processed this cycle
      if (!advance) begin
         adc_cmd = '0;
         dac_cmd = '0;
      end
      adc_cmd.capture = advance;
   end

   always_comb begin
      if (!pop_go) begin
         pop_mask_in = '0;
      end else if (pop_size == 4'd1) begin
         pop_mask_in = 32'h0000_00ff;
      end else if (pop_size == 4'd2) begin
         pop_mask_in = 32'h0000_ffff;
      end else begin
         pop_mask_in = 32'hffff_ffff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         adc_ctrl_ff <= '0;
         train_ff    <= TRAIN_RESET;
         dac_ctrl_ff <= DACCFG_FIXED;
         dac_dma_ff  <= '0;
         overrun_ff  <= 1'b0;
         underrun_ff <= 1'b0;
      end else if (advance) begin
         adc_ctrl_ff <= adc_ctrl_in;
         train_ff    <= train_in;
         dac_ctrl_ff <= dac_ctrl_in;
         dac_dma_ff  <= dac_dma_in;
         overrun_ff  <= overrun_in;
         underrun_ff <= underrun_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rd_ff       <= rd_in;
         pop_mask_ff <= pop_mask_in;
         adc_rdy_ff  <= adc_ctrl_in[0] && (smp_fill_next != '0);
         dac_rdy_ff  <= dac_dma_in[0] && (dq_fill_next != DAC_CW'(DAC_DEPTH));
         drain_ff    <= drain_next;
      end
   end

   adf_sample_fifo #(
      .ADC_DEPTH (ADC_DEPTH)
   ) u_sample_fifo (
      .clock      (clock),
      .reset      (reset),
      .cmd        (adc_cmd),
      .wr_data    (data_ff[SAMPLE_W-1:0]),
      .count      (smp_fill),
      .count_next (smp_fill_next),
      .sample     (sample)
   );

   adf_dac_fifo #(
      .DAC_DEPTH (DAC_DEPTH)
   ) u_dac_fifo (
      .clock      (clock),
      .reset      (reset),
      .cmd        (dac_cmd),
      .tail       (dq_ptr),
      .count      (dq_fill),
      .count_next (dq_fill_next),
      .drain_next (drain_next)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'd0, drain_ff, dac_rdy_ff, adc_rdy_ff,
                        rd_ff | (32'(sample) & pop_mask_ff)};

endmodule

// ----- design/adf_sample_fifo.sv -----
// ---------------------------------------------------------------------------
// adf_sample_fifo: ADC sample storage
// Circular sample store with head, tail and count; the head sample is read
// into a register on each processed word.
// ---------------------------------------------------------------------------
module adf_sample_fifo #(
   parameter int ADC_DEPTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  adf_pkg::adc_cmd_type          cmd,
   input  logic [adf_pkg::SAMPLE_W-1:0]  wr_data,
   output logic [$clog2(ADC_DEPTH+1)-1:0] count,
   output logic [$clog2(ADC_DEPTH+1)-1:0] count_next,
   output logic [adf_pkg::SAMPLE_W-1:0]  sample
);
   import adf_pkg::*;

   localparam int AW = $clog2(ADC_DEPTH);
   localparam int CW = $clog2(ADC_DEPTH + 1);

   logic [SAMPLE_W-1:0] store_mem [ADC_DEPTH];
   logic [AW-1:0] head_ff, head_in;
   logic [AW-1:0] tail_ff, tail_in;
   logic [CW-1:0] count_ff, count_in;
   logic [SAMPLE_W-1:0] sample_ff;

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (cmd.clear) begin
         head_in  = '0;
         tail_in  = '0;
         count_in = '0;
      end else if (cmd.push) begin
         tail_in  = (tail_ff == AW'(ADC_DEPTH - 1)) ? '0 : tail_ff + 1'b1;
         count_in = count_ff + 1'b1;
      end else if (cmd.pop) begin
         head_in  = (head_ff == AW'(ADC_DEPTH - 1)) ? '0 : head_ff + 1'b1;
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         store_mem[tail_ff] <= wr_data;
      end
      if (cmd.capture) begin
         sample_ff <= store_mem[head_ff];
      end
   end

   assign count      = count_ff;
   assign count_next = count_in;
   assign sample     = sample_ff;

endmodule

// ----- design/adf_dac_fifo.sv -----
// ---------------------------------------------------------------------------
// adf_dac_fifo: DAC write queue tracking
// Keeps the DAC tail pointer, the entry count and the drain schedule.
// ---------------------------------------------------------------------------
module adf_dac_fifo #(
   parameter int DAC_DEPTH = 4
) (
   input  logic                        clock,
   input  logic                        reset,
   input  adf_pkg::dac_cmd_type        cmd,
   output logic [adf_pkg::DAC_TW-1:0]  tail,
   output logic [adf_pkg::DAC_CW-1:0]  count,
   output logic [adf_pkg::DAC_CW-1:0]  count_next,
   output logic                        drain_next
);
   import adf_pkg::*;

   logic [DAC_TW-1:0] tail_ff, tail_in;
   logic [DAC_CW-1:0] count_ff, count_in;
   logic              sched_ff, sched_in;
   logic              push_go;

   assign push_go = cmd.push && (count_ff != DAC_CW'(DAC_DEPTH));

   always_comb begin
      tail_in  = tail_ff;
      count_in = count_ff;
      sched_in = sched_ff;
      if (cmd.drain) begin
         if (sched_ff) begin
            tail_in  = '0;
            count_in = '0;
            sched_in = 1'b0;
         end
      end else begin
         if (push_go) begin
            tail_in  = (tail_ff == DAC_TW'(DAC_DEPTH - 1)) ? '0 : tail_ff + 1'b1;
            count_in = count_ff + 1'b1;
         end
         // a dropped push on a full queue leaves the schedule alone
         if ((push_go || cmd.check) && cmd.can && (count_in != '0)) begin
            sched_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tail_ff  <= '0;
         count_ff <= '0;
         sched_ff <= 1'b0;
      end else begin
         tail_ff  <= tail_in;
         count_ff <= count_in;
         sched_ff <= sched_in;
      end
   end

   assign tail       = tail_ff;
   assign count      = count_ff;
   assign count_next = count_in;
   assign drain_next = sched_in;

endmodule

// ----- tb/tb_top.sv -----
// ---------------------------------------------------------------------------
// tb_top: converter interface register block testbench
// Streams bus reads and writes, ADC sample pushes, DMA pops, DAC DMA writes
// and drain ticks into the block and checks every response word against a
// cycle-free shadow of the registers and both FIFOs. Random valid/ready
// gaps on both sides, with a stretch of back-to-back traffic.
// ---------------------------------------------------------------------------
module tb_top;
   import adf_pkg::*;

   localparam int ADC_DEPTH = 32;
   localparam int DAC_DEPTH = 4;

   typedef struct packed {
      logic [2:0]  op;
      logic [11:0] offset;
      logic [3:0]  size;
      logic [31:0] data;
   } req_word_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic        adc_rdy;
      logic        dac_rdy;
      logic        drain;
   } rsp_word_type;

   typedef enum int {MODE_MIX, MODE_FILL, MODE_EMPTY, MODE_DAC} stim_mode_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [2:0]  req_tuser = '0;
   logic [47:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;

   adc_dac_fifo_register_block u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // shadow copy of the block state
   logic [31:0] sh_adc_ctrl;
   logic [31:0] sh_train;
   logic [31:0] sh_dac_cfg;
   logic [7:0]  sh_dac_dma;
   logic        sh_overrun;
   logic        sh_underrun;
   logic [25:0] sh_samples [ADC_DEPTH];
   logic [4:0]  sh_head;
   logic [4:0]  sh_tail;
   logic [5:0]  sh_count;
   logic [1:0]  sh_dq_ptr;
   logic [2:0]  sh_dq_fill;
   logic        sh_drain;

   req_word_type req_pending [$];
   rsp_word_type rsp_want [$];
   req_word_type cur_req;
   rsp_word_type want_word;
   int           sent_cnt = 0;
   int           got_cnt = 0;
   int           err_cnt = 0;

   function automatic void drain_check();
      if ((sh_dac_cfg[0] || sh_dac_dma[0]) && sh_dq_fill != 0)
         sh_drain = 1'b1;
   endfunction

   function automatic void dac_push();
      if (sh_dq_fill < DAC_DEPTH) begin
         sh_dq_ptr  = sh_dq_ptr + 2'd1;
         sh_dq_fill = sh_dq_fill + 3'd1;
         drain_check();
      end
   endfunction

   function automatic logic [31:0] sample_pop(logic [3:0] width);
      logic [31:0] v;
      if (width > 4'd4 || !sh_adc_ctrl[0] || sh_count == 0) begin
         sh_underrun = 1'b1;
         return '0;
      end
      v        = {6'd0, sh_samples[sh_head]};
      sh_head  = sh_head + 5'd1;
      sh_count = sh_count - 6'd1;
      if (width == 4'd1) return v & 32'h0000_00ff;
      if (width == 4'd2) return v & 32'h0000_ffff;
      return v;
   endfunction

   function automatic logic [31:0] bus_read(logic [11:0] off);
      logic [31:0] v;
      v = '0;
      case (off)
         REG_ADC_CFG: begin
            v        = sh_adc_ctrl & ADC_CTRL_MASK;
            v[2]     = (sh_count != 0);
            v[4]     = (sh_count != 0);
            v[3]     = (sh_count >= ADC_DEPTH);
            v[5]     = sh_overrun;
            v[6]     = sh_underrun;
            v[21:16] = sh_count;
         end
         REG_ADC_DATA:  v = sample_pop(BUS_SIZE);
         REG_TRAIN:     v = sh_train;
         REG_DAC_CFG:   v = sh_dac_cfg;
         REG_DAC_DMA:   v = {24'd0, sh_dac_dma};
         REG_DAC_STATUS: begin
            v[0]   = (sh_dq_fill == 0);
            v[7:4] = (sh_dq_fill == 0) ? 4'd8 : 4'd0;
            v[1]   = (sh_dq_fill >= DAC_DEPTH);
            v[9:8] = sh_dq_ptr;
         end
         default: v = '0;
      endcase
      return v;
   endfunction

   function automatic void bus_write(logic [11:0] off, logic [31:0] val);
      case (off)
         REG_ADC_CFG: begin
            sh_adc_ctrl = val & ADC_CTRL_MASK;
            if (val[1]) begin
               sh_head  = '0;
               sh_tail  = '0;
               sh_count = '0;
            end
            if (val[9])  sh_overrun  = 1'b0;
            if (val[10]) sh_underrun = 1'b0;
         end
         REG_TRAIN:    sh_train = (sh_train & ~TRAIN_MASK) | (val & TRAIN_MASK);
         REG_DAC_CFG: begin
            sh_dac_cfg = DACCFG_FIXED | (val & DACCFG_MASK);
            drain_check();
         end
         REG_DAC_DMA: begin
            sh_dac_dma = val[7:0] & DACDMA_MASK;
            drain_check();
         end
         REG_DAC_DATA: dac_push();
         default: ;
      endcase
   endfunction

   // expected response word for one accepted request; updates the shadow
   function automatic rsp_word_type regblock_step(req_word_type it);
      rsp_word_type r;
      logic         bus_ok;
      r = '0;
      // a 12-bit offset is always inside the 4 KB window
      bus_ok = (it.size == BUS_SIZE) && (it.offset[1:0] == 2'b00);
      case (it.op)
         OP_BUS_READ:  if (bus_ok) r.read_data = bus_read(it.offset);
         OP_BUS_WRITE: if (bus_ok) bus_write(it.offset, it.data);
         OP_ADC_PUSH: begin
            if (sh_count >= ADC_DEPTH) begin
               sh_overrun = 1'b1;
            end else begin
               sh_samples[sh_tail] = it.data[25:0];
               sh_tail  = sh_tail + 5'd1;
               sh_count = sh_count + 6'd1;
            end
         end
         OP_DMA_POP:   r.read_data = sample_pop(it.size);
         OP_DMA_DAC:   dac_push();
         OP_DRAIN: begin
            if (sh_drain) begin
               sh_drain   = 1'b0;
               sh_dq_ptr  = '0;
               sh_dq_fill = '0;
            end
         end
         default: ;
      endcase
      r.adc_rdy = sh_adc_ctrl[0] && (sh_count != 0);
      r.dac_rdy = sh_dac_dma[0] && (sh_dq_fill < DAC_DEPTH);
      r.drain   = sh_drain;
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      if (err_cnt < 100)
         $display("tb_top: word %0d %s: got %h want %h", got_cnt, what, got, want);
      err_cnt++;
   endtask

   task automatic queue_req(logic [2:0] op, logic [11:0] off, logic [3:0] size,
                            logic [31:0] data);
      req_word_type it;
      it.op     = op;
      it.offset = off;
      it.size   = size;
      it.data   = data;
      req_pending.push_back(it);
   endtask

   // offset, size and data for a bus access
   function automatic req_word_type bus_fields(req_word_type it);
      logic [31:0] raw;
      raw = $urandom;
      if ($urandom_range(99) < 85) begin
         case ($urandom_range(7))
            0: it.offset = REG_ADC_CFG;
            1: it.offset = REG_ADC_DATA;
            2: it.offset = REG_TRAIN;
            3: it.offset = REG_DAC_CFG;
            4: it.offset = REG_DAC_DMA;
            5: it.offset = REG_DAC_DATA;
            6: it.offset = REG_DAC_STATUS;
            default: it.offset = {raw[11:2], 2'b00};
         endcase
      end else begin
         it.offset = raw[11:0];
      end
      it.size = ($urandom_range(99) < 90) ? BUS_SIZE : 4'($urandom_range(15));
      it.data = $urandom;
      if (it.offset == REG_ADC_CFG) begin
         it.data[0] = ($urandom_range(99) < 85);
         it.data[1] = ($urandom_range(99) < 10);
      end else if (it.offset == REG_DAC_CFG || it.offset == REG_DAC_DMA) begin
         it.data[0] = ($urandom_range(99) < 70);
      end
      return it;
   endfunction

   function automatic req_word_type pick_item(stim_mode_type mode);
      req_word_type it;
      int           roll;
      it.op     = OP_DRAIN;
      it.offset = 12'($urandom);
      it.size   = 4'($urandom_range(1, 8));
      it.data   = $urandom;
      if ($urandom_range(99) < 8) begin
         // noise: any code, any field value
         it.op   = 3'($urandom_range(7));
         it.size = 4'($urandom);
         return it;
      end
      roll = $urandom_range(99);
      case (mode)
         MODE_FILL: begin
            if (roll < 85)      it.op = OP_ADC_PUSH;
            else if (roll < 93) begin it.op = OP_BUS_READ; it = bus_fields(it); end
            else                begin it.op = OP_BUS_WRITE; it = bus_fields(it); end
         end
         MODE_EMPTY: begin
            if (roll < 60) begin
               it.op = OP_DMA_POP;
               case ($urandom_range(9))
                  0, 1, 2: it.size = 4'd1;
                  3, 4, 5: it.size = 4'd2;
                  6, 7:    it.size = 4'd4;
                  default: it.size = 4'($urandom);
               endcase
            end else if (roll < 75) begin
               it.op     = OP_BUS_READ;
               it.offset = REG_ADC_DATA;
               it.size   = BUS_SIZE;
            end else if (roll < 85) begin
               it.op = OP_BUS_READ;
               it    = bus_fields(it);
            end else begin
               it.op = OP_BUS_WRITE;
               it    = bus_fields(it);
            end
         end
         MODE_DAC: begin
            if (roll < 35) begin
               it.op   = OP_DMA_DAC;
               it.size = 4'($urandom);
            end else if (roll < 50) begin
               it.op     = OP_BUS_WRITE;
               it.offset = REG_DAC_DATA;
               it.size   = BUS_SIZE;
            end else if (roll < 65) begin
               it.op = OP_DRAIN;
            end else if (roll < 80) begin
               it.op = OP_BUS_WRITE;
               it    = bus_fields(it);
            end else begin
               it.op = OP_BUS_READ;
               it    = bus_fields(it);
            end
         end
         default: begin
            if (roll < 25)      begin it.op = OP_BUS_READ; it = bus_fields(it); end
            else if (roll < 45) begin it.op = OP_BUS_WRITE; it = bus_fields(it); end
            else if (roll < 60) it.op = OP_ADC_PUSH;
            else if (roll < 75) it.op = OP_DMA_POP;
            else if (roll < 85) it.op = OP_DMA_DAC;
            else if (roll < 95) it.op = OP_DRAIN;
            else                it.op = 3'($urandom_range(6, 7));
         end
      endcase
      return it;
   endfunction

   task automatic queue_random(int n);
      int            left;
      int            run;
      stim_mode_type mode;
      left = n;
      while (left > 0) begin
         mode = stim_mode_type'($urandom_range(3));
         run  = $urandom_range(30, 70);
         if (run > left) run = left;
         repeat (run) req_pending.push_back(pick_item(mode));
         left -= run;
      end
   endtask

   task automatic wait_quiet();
      while (req_pending.size() != 0 || req_tvalid || rsp_want.size() != 0)
         @(negedge clock);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            rsp_want.push_back(regblock_step(cur_req));
            sent_cnt++;
         end
         if (!req_tvalid || req_tready) begin
            if (req_pending.size() != 0 &&
                ((sent_cnt >= 500 && sent_cnt < 700) || $urandom_range(99) >= 29)) begin
               cur_req = req_pending.pop_front();
               req_tuser  <= cur_req.op;
               req_tdata  <= {cur_req.data, cur_req.size, cur_req.offset};
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (rsp_want.size() == 0) begin
               report_mismatch("unexpected word", rsp_tdata[31:0], '0);
            end else begin
               want_word = rsp_want.pop_front();
               if (rsp_tdata[31:0] !== want_word.read_data)
                  report_mismatch("read_data", rsp_tdata[31:0], want_word.read_data);
               if (rsp_tdata[32] !== want_word.adc_rdy)
                  report_mismatch("adc_dma_ready", 32'(rsp_tdata[32]), 32'(want_word.adc_rdy));
               if (rsp_tdata[33] !== want_word.dac_rdy)
                  report_mismatch("dac_dma_ready", 32'(rsp_tdata[33]), 32'(want_word.dac_rdy));
               if (rsp_tdata[34] !== want_word.drain)
                  report_mismatch("drain_pending", 32'(rsp_tdata[34]), 32'(want_word.drain));
            end
            got_cnt++;
         end
         rsp_tready <= (got_cnt >= 500 && got_cnt < 700) || ($urandom_range(99) >= 29);
      end
   end

   initial begin
      sh_adc_ctrl = '0;
      sh_train    = TRAIN_RESET;
      sh_dac_cfg  = DACCFG_FIXED;
      sh_dac_dma  = '0;
      sh_overrun  = 1'b0;
      sh_underrun = 1'b0;
      sh_head     = '0;
      sh_tail     = '0;
      sh_count    = '0;
      sh_dq_ptr   = '0;
      sh_dq_fill  = '0;
      sh_drain    = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // power-on values
      queue_req(OP_BUS_READ, REG_ADC_CFG, BUS_SIZE, 32'h0);
      queue_req(OP_BUS_READ, REG_TRAIN, BUS_SIZE, 32'h0);
      queue_req(OP_BUS_READ, REG_DAC_CFG, BUS_SIZE, 32'h0);
      queue_req(OP_BUS_READ, REG_DAC_STATUS, BUS_SIZE, 32'h0);
      // pop with ADC DMA off underruns
      queue_req(OP_DMA_POP, 12'h000, 4'd4, 32'h0);
      // enable, clear FIFO and both flags at once
      queue_req(OP_BUS_WRITE, REG_ADC_CFG, BUS_SIZE, 32'hffff_ffff);
      queue_req(OP_ADC_PUSH, 12'hfff, 4'd15, 32'hffff_ffff);
      queue_req(OP_ADC_PUSH, 12'h000, 4'd0, 32'h0000_0000);
      queue_req(OP_ADC_PUSH, 12'h000, 4'd1, 32'h0155_aaaa);
      queue_req(OP_DMA_POP, 12'h000, 4'd1, 32'h0);
      queue_req(OP_DMA_POP, 12'h000, 4'd2, 32'h0);
      // too wide: fails even with samples present
      queue_req(OP_DMA_POP, 12'h000, 4'd8, 32'h0);
      queue_req(OP_BUS_READ, REG_ADC_DATA, BUS_SIZE, 32'h0);
      queue_req(OP_DMA_POP, 12'h000, 4'd4, 32'h0);
      queue_req(OP_BUS_READ, REG_ADC_CFG, BUS_SIZE, 32'h0);
      queue_req(OP_BUS_WRITE, REG_TRAIN, BUS_SIZE, 32'hffff_ffff);
      queue_req(OP_BUS_WRITE, REG_DAC_CFG, BUS_SIZE, 32'hffff_ffff);
      queue_req(OP_BUS_WRITE, REG_DAC_DMA, BUS_SIZE, 32'hffff_ffff);
      // fill the DAC queue, then one more that is dropped
      queue_req(OP_DMA_DAC, 12'h000, 4'd1, 32'h1234_5678);
      queue_req(OP_DMA_DAC, 12'h000, 4'd2, 32'hffff_ffff);
      queue_req(OP_DMA_DAC, 12'h000, 4'd4, 32'h0);
      queue_req(OP_BUS_WRITE, REG_DAC_DATA, BUS_SIZE, 32'h0);
      queue_req(OP_DMA_DAC, 12'h000, 4'd4, 32'h0);
      queue_req(OP_BUS_READ, REG_DAC_STATUS, BUS_SIZE, 32'h0);
      queue_req(OP_DRAIN, 12'h000, 4'd0, 32'h0);
      queue_req(OP_DRAIN, 12'h000, 4'd0, 32'h0);
      // bad size, misaligned, unmapped
      queue_req(OP_BUS_READ, REG_ADC_CFG, 4'd2, 32'h0);
      queue_req(OP_BUS_READ, 12'h002, BUS_SIZE, 32'h0);
      queue_req(OP_BUS_WRITE, REG_TRAIN, 4'd8, 32'h0);
      queue_req(OP_BUS_READ, 12'hffc, BUS_SIZE, 32'h0);
      // unused operation codes
      queue_req(3'd6, 12'hfff, 4'd4, 32'hffff_ffff);
      queue_req(3'd7, 12'h040, 4'd4, 32'h0000_0001);

      wait_quiet();
      queue_random(550);
      // sender holds off until everything is back
      wait_quiet();
      queue_random(550);
      wait_quiet();
      repeat (8) @(negedge clock);
      if (err_cnt == 0 && rsp_want.size() == 0)
         $display("tb_top: done, clean");
      else
         $display("tb_top: done, errors");
      $finish;
   end

   initial begin
      #4_000_000;
      $display("tb_top: done, errors");
      $finish;
   end

endmodule
